/* rtl/pha_pkg.sv */
// Shared types, constants and arithmetic step functions for the probe hit angle block.
package pha_pkg;

  localparam int NumTypes     = 4;
  localparam int NumStepRegs  = 4;
  localparam int StepIdxW     = 2;
  localparam int CfgAddrW     = 8;
  localparam int StepW        = 31;
  localparam int FifoDepth    = 2;
  localparam int FifoPtrW     = 1;
  localparam int FifoCntW     = 2;
  localparam int SqrtStages   = 32;
  localparam int MSqrtStages  = 31;
  localparam int DivStages    = 34;
  localparam int CordicStages = 20;
  localparam int AngW         = 26;

  localparam logic [AngW-1:0] QuarterTurn = 26'd5898240;
  localparam logic [AngW-1:0] HalfTurn    = 26'd11796480;
  localparam logic [AngW-1:0] FullTurn    = 26'd23592960;
  localparam logic [AngW:0]   RoundHalf   = 27'd32768;
  localparam logic [8:0]      Deg360      = 9'd360;

  typedef struct packed {
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] vel_x;
    logic signed [31:0] vel_y;
    logic signed [31:0] probe_center_x;
    logic signed [31:0] probe_center_y;
    logic [30:0]        probe_radius;
    logic [1:0]         particle_type;
  } in_item_t;

  typedef struct packed {
    logic [8:0] hit_angle_deg;
    logic       geometry_error;
  } out_item_t;

  // Item after classification by the front end.
  typedef struct packed {
    logic signed [31:0] vx;
    logic signed [31:0] vy;
    logic signed [32:0] dx;
    logic signed [32:0] dy;
    logic [30:0]        rad;
    logic [StepW-1:0]   dt;
    logic               zero_spd;
  } fe_item_t;

  // Fields carried alongside the geometry pipeline.
  typedef struct packed {
    logic signed [31:0] vx;
    logic signed [31:0] vy;
    logic [30:0]        rad;
    logic [StepW-1:0]   dt;
    logic               err;
  } gcarry_t;

  // Crossing vector handed from the geometry part to the angle part.
  typedef struct packed {
    logic signed [64:0] hx;
    logic signed [64:0] hy;
    logic               err;
  } geo_res_t;

  typedef struct packed {
    logic [63:0] rem;
    logic [63:0] root;
  } sqrt_st_t;

  typedef struct packed {
    logic [63:0] rem;
    logic        q;
  } div_st_t;

  // One digit of the integer square root, test bit 4^k.
  function automatic sqrt_st_t sqrt_step(sqrt_st_t s, int unsigned k);
    logic [63:0] bitv;
    logic [64:0] t;
    sqrt_st_t    o;
    bitv = 64'd1 << (2 * k);
    t    = {1'b0, s.root} + {1'b0, bitv};
    if ({1'b0, s.rem} >= t) begin
      o.rem  = s.rem - t[63:0];
      o.root = (s.root >> 1) + bitv;
    end else begin
      o.rem  = s.rem;
      o.root = s.root >> 1;
    end
    return o;
  endfunction

  // One quotient bit of restoring division, divisor weighted by 2^k.
  function automatic div_st_t div_step(logic [63:0] rem, logic [31:0] d, int unsigned k);
    logic [65:0] t;
    div_st_t     o;
    t = {34'd0, d} << k;
    if ({2'b00, rem} >= t) begin
      o.rem = rem - t[63:0];
      o.q   = 1'b1;
    end else begin
      o.rem = rem;
      o.q   = 1'b0;
    end
    return o;
  endfunction

  // Position of the most significant set bit.
  function automatic logic [5:0] lead_one(logic [63:0] v);
    logic [5:0] p;
    p = '0;
    for (int i = 0; i < 64; i++) begin
      if (v[i]) begin
        p = 6'(i);
      end
    end
    return p;
  endfunction

  // Arctangent of 2^-i in units of 2^-16 degree.
  function automatic logic [AngW-1:0] atan_deg(int unsigned i);
    logic [AngW-1:0] a;
    case (i)
      0:       a = 26'd2949120;
      1:       a = 26'd1740967;
      2:       a = 26'd919879;
      3:       a = 26'd466945;
      4:       a = 26'd234379;
      5:       a = 26'd117304;
      6:       a = 26'd58666;
      7:       a = 26'd29335;
      8:       a = 26'd14668;
      9:       a = 26'd7334;
      10:      a = 26'd3667;
      11:      a = 26'd1833;
      12:      a = 26'd917;
      13:      a = 26'd458;
      14:      a = 26'd229;
      15:      a = 26'd115;
      16:      a = 26'd57;
      17:      a = 26'd29;
      18:      a = 26'd14;
      19:      a = 26'd7;
      default: a = '0;
    endcase
    return a;
  endfunction

endpackage

/* rtl/pha_front.sv */
// Front end: step-time registers, input capture and classification of each particle.
module pha_front (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start,
  output logic                          busy,
  input  logic                          cfg_we_i,
  input  logic [pha_pkg::CfgAddrW-1:0]  cfg_addr_i,
  input  logic [pha_pkg::StepW-1:0]     cfg_wdata_i,
  input  pha_pkg::in_item_t             item_i,
  input  logic                          fifo_full_i,
  output logic                          fe_valid_o,
  output pha_pkg::fe_item_t             fe_item_o
);

  logic [pha_pkg::StepW-1:0]    step_q [pha_pkg::NumStepRegs];
  logic                         fe_valid_q, fe_valid_d;
  pha_pkg::fe_item_t            fe_item_q, fe_item_d;
  logic [pha_pkg::StepIdxW-1:0] sel;
  logic                         take;

  // The front register holds while the queue is full.
  assign busy       = fe_valid_q & fifo_full_i;
  assign take       = start & ~busy;
  assign fe_valid_d = busy | start;

  always_comb begin
    sel = ({1'b0, item_i.particle_type} >= 3'(pha_pkg::NumTypes)) ?
          pha_pkg::StepIdxW'(pha_pkg::NumTypes - 1) : item_i.particle_type;
    fe_item_d.vx       = item_i.vel_x;
    fe_item_d.vy       = item_i.vel_y;
    fe_item_d.dx       = 33'(item_i.pos_x) - 33'(item_i.probe_center_x);
    fe_item_d.dy       = 33'(item_i.pos_y) - 33'(item_i.probe_center_y);
    fe_item_d.rad      = item_i.probe_radius;
    fe_item_d.dt       = step_q[sel];
    fe_item_d.zero_spd = (item_i.vel_x == '0) && (item_i.vel_y == '0);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fe_valid_q <= 1'b0;
      for (int i = 0; i < pha_pkg::NumStepRegs; i++) begin
        step_q[i] <= '0;
      end
    end else begin
      fe_valid_q <= fe_valid_d;
      if (cfg_we_i && (cfg_addr_i < pha_pkg::CfgAddrW'(pha_pkg::NumStepRegs))) begin
        step_q[cfg_addr_i[pha_pkg::StepIdxW-1:0]] <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      fe_item_q <= fe_item_d;
    end
  end

  assign fe_valid_o = fe_valid_q;
  assign fe_item_o  = fe_item_q;

endmodule

/* rtl/pha_fifo.sv */
// Short queue between the front end and the arithmetic back end.
module pha_fifo (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  pha_pkg::fe_item_t data_i,
  output logic              full_o,
  input  logic              pop_i,
  output logic              valid_o,
  output pha_pkg::fe_item_t data_o
);

  pha_pkg::fe_item_t             mem_q [pha_pkg::FifoDepth];
  logic [pha_pkg::FifoPtrW-1:0]  wr_ptr_q, rd_ptr_q;
  logic [pha_pkg::FifoCntW-1:0]  cnt_q;
  logic                          do_push, do_pop;

  assign full_o  = (cnt_q == pha_pkg::FifoCntW'(pha_pkg::FifoDepth));
  assign valid_o = (cnt_q != '0);
  assign do_push = push_i & ~full_o;
  assign do_pop  = pop_i & valid_o;
  assign data_o  = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == pha_pkg::FifoPtrW'(pha_pkg::FifoDepth - 1)) ?
                    '0 : wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == pha_pkg::FifoPtrW'(pha_pkg::FifoDepth - 1)) ?
                    '0 : rd_ptr_q + 1'b1;
      end
      cnt_q <= cnt_q + pha_pkg::FifoCntW'(do_push) - pha_pkg::FifoCntW'(do_pop);
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

/* rtl/pha_geom.sv */
// Geometry pipeline: speed, path offsets, chord half length and the crossing vector.
module pha_geom (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  pha_pkg::fe_item_t in_item_i,
  output logic              out_valid_o,
  output pha_pkg::geo_res_t out_o
);

  localparam int NS = pha_pkg::SqrtStages;
  localparam int ND = pha_pkg::DivStages;
  localparam int NM = pha_pkg::MSqrtStages;

  typedef struct packed {
    logic [63:0] cr_mag;
    logic        cr_neg;
    logic [63:0] s_mag;
    logic        s_neg;
  } ds_t;

  typedef struct packed {
    logic [63:0] rc;
    logic [63:0] rs;
    logic [33:0] qc;
    logic [33:0] qs;
    logic [31:0] sp;
    logic        cn;
    logic        sn;
  } dv_t;

  typedef struct packed {
    logic signed [31:0] h;
    logic signed [34:0] q;
    logic [62:0]        rhs;
  } mc_t;

  function automatic dv_t dv_next(dv_t s, int unsigned k);
    pha_pkg::div_st_t a;
    pha_pkg::div_st_t b;
    dv_t              o;
    a    = pha_pkg::div_step(s.rc, s.sp, k);
    b    = pha_pkg::div_step(s.rs, s.sp, k);
    o    = s;
    o.rc = a.rem;
    o.rs = b.rem;
    o.qc = s.qc | (34'(a.q) << k);
    o.qs = s.qs | (34'(b.q) << k);
    return o;
  endfunction

  // Stage 1: products.
  logic signed [63:0] vxx_w, vyy_w;
  logic signed [64:0] vxdy_w, vydx_w, vxdx_w, vydy_w;
  logic               s1_v_q;
  pha_pkg::gcarry_t   s1_c_q;
  logic signed [63:0] s1_vxx_q, s1_vyy_q;
  logic signed [64:0] s1_vxdy_q, s1_vydx_q, s1_vxdx_q, s1_vydy_q;

  assign vxx_w  = in_item_i.vx * in_item_i.vx;
  assign vyy_w  = in_item_i.vy * in_item_i.vy;
  assign vxdy_w = in_item_i.vx * in_item_i.dy;
  assign vydx_w = in_item_i.vy * in_item_i.dx;
  assign vxdx_w = in_item_i.vx * in_item_i.dx;
  assign vydy_w = in_item_i.vy * in_item_i.dy;

  // Stage 2 feeds the speed square root.
  logic signed [65:0] crd_w, sd_w, crn_w, sdn_w;
  ds_t                ds_w;
  pha_pkg::sqrt_st_t  sq0_w;

  always_comb begin
    crd_w         = s1_vxdy_q - s1_vydx_q;
    sd_w          = s1_vxdx_q + s1_vydy_q;
    crn_w         = -crd_w;
    sdn_w         = -sd_w;
    ds_w.cr_neg   = crd_w[65];
    ds_w.cr_mag   = crd_w[65] ? crn_w[63:0] : crd_w[63:0];
    ds_w.s_neg    = sd_w[65];
    ds_w.s_mag    = sd_w[65] ? sdn_w[63:0] : sd_w[63:0];
    sq0_w.rem     = $unsigned(s1_vxx_q) + $unsigned(s1_vyy_q);
    sq0_w.root    = '0;
  end

  pha_pkg::sqrt_st_t sq_q   [0:NS];
  ds_t               sqd_q  [0:NS];
  pha_pkg::gcarry_t  sqc_q  [0:NS];
  logic              sqv_q  [0:NS];

  // Division of both path products by the speed.
  dv_t               dv0_w;
  dv_t               dv_q   [1:ND];
  pha_pkg::gcarry_t  dvc_q  [1:ND];
  logic              dvv_q  [1:ND];

  always_comb begin
    dv0_w.rc = sqd_q[NS].cr_mag;
    dv0_w.rs = sqd_q[NS].s_mag;
    dv0_w.qc = '0;
    dv0_w.qs = '0;
    dv0_w.sp = sq_q[NS].root[31:0];
    dv0_w.cn = sqd_q[NS].cr_neg;
    dv0_w.sn = sqd_q[NS].s_neg;
  end

  // Stage 3: signed offsets and the miss check.
  logic signed [31:0] h_w;
  logic signed [34:0] q_w;
  logic               miss_w;
  logic               s3_v_q;
  pha_pkg::gcarry_t   s3_c_q;
  logic [30:0]        s3_hq_q;
  logic signed [31:0] s3_h_q;
  logic signed [34:0] s3_q_q;
  logic [31:0]        s3_sp_q;

  always_comb begin
    h_w    = dv_q[ND].cn ? -$signed({1'b0, dv_q[ND].qc[30:0]}) :
                            $signed({1'b0, dv_q[ND].qc[30:0]});
    q_w    = dv_q[ND].sn ? -$signed({1'b0, dv_q[ND].qs}) : $signed({1'b0, dv_q[ND].qs});
    miss_w = dv_q[ND].qc > 34'(dvc_q[ND].rad);
  end

  // Stage 4: squares and the step bound.
  logic               s4_v_q;
  pha_pkg::gcarry_t   s4_c_q;
  logic [61:0]        s4_rr_q, s4_hh_q;
  logic [62:0]        s4_rhs_q;
  logic signed [31:0] s4_h_q;
  logic signed [34:0] s4_q_q;

  // Stage 5 and on: chord half length square root.
  pha_pkg::sqrt_st_t  mq_q   [0:NM];
  mc_t                mqm_q  [0:NM];
  pha_pkg::gcarry_t   mqc_q  [0:NM];
  logic               mqv_q  [0:NM];
  logic [61:0]        msq_w;

  assign msq_w = s4_rr_q - s4_hh_q;

  // Stage 6: choose the crossing.
  logic [30:0]        m_w;
  logic signed [35:0] qm_w;
  logic signed [63:0] lhs_w, rhs_w;
  logic               s6_v_q;
  pha_pkg::gcarry_t   s6_c_q;
  logic               s6_later_q;
  logic [30:0]        s6_m_q;
  logic signed [31:0] s6_h_q;

  always_comb begin
    m_w   = mq_q[NM].root[30:0];
    qm_w  = 36'(mqm_q[NM].q) + 36'($signed({1'b0, m_w}));
    lhs_w = {{12{qm_w[35]}}, qm_w, 16'd0};
    rhs_w = $signed({1'b0, mqm_q[NM].rhs});
  end

  // Stage 7: crossing vector products.
  logic signed [31:0] mm_w;
  logic signed [63:0] hvy_w, mvx_w, hvx_w, mvy_w;
  logic               s7_v_q;
  logic               s7_err_q;
  logic signed [63:0] s7_hvy_q, s7_mvx_q, s7_hvx_q, s7_mvy_q;

  always_comb begin
    mm_w  = s6_later_q ? -$signed({1'b0, s6_m_q}) : $signed({1'b0, s6_m_q});
    hvy_w = s6_h_q * s6_c_q.vy;
    mvx_w = mm_w * s6_c_q.vx;
    hvx_w = s6_h_q * s6_c_q.vx;
    mvy_w = mm_w * s6_c_q.vy;
  end

  // Stage 8: sums.
  logic              s8_v_q;
  pha_pkg::geo_res_t s8_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q     <= 1'b0;
      s3_v_q     <= 1'b0;
      s4_v_q     <= 1'b0;
      s6_v_q     <= 1'b0;
      s7_v_q     <= 1'b0;
      s8_v_q     <= 1'b0;
      for (int j = 0; j <= NS; j++) begin
        sqv_q[j] <= 1'b0;
      end
      for (int j = 1; j <= ND; j++) begin
        dvv_q[j] <= 1'b0;
      end
      for (int j = 0; j <= NM; j++) begin
        mqv_q[j] <= 1'b0;
      end
    end else begin
      s1_v_q   <= in_valid_i;
      sqv_q[0] <= s1_v_q;
      for (int j = 0; j < NS; j++) begin
        sqv_q[j+1] <= sqv_q[j];
      end
      dvv_q[1] <= sqv_q[NS];
      for (int j = 1; j < ND; j++) begin
        dvv_q[j+1] <= dvv_q[j];
      end
      s3_v_q   <= dvv_q[ND];
      s4_v_q   <= s3_v_q;
      mqv_q[0] <= s4_v_q;
      for (int j = 0; j < NM; j++) begin
        mqv_q[j+1] <= mqv_q[j];
      end
      s6_v_q   <= mqv_q[NM];
      s7_v_q   <= s6_v_q;
      s8_v_q   <= s7_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    s1_c_q.vx  <= in_item_i.vx;
    s1_c_q.vy  <= in_item_i.vy;
    s1_c_q.rad <= in_item_i.rad;
    s1_c_q.dt  <= in_item_i.dt;
    s1_c_q.err <= in_item_i.zero_spd;
    s1_vxx_q   <= vxx_w;
    s1_vyy_q   <= vyy_w;
    s1_vxdy_q  <= vxdy_w;
    s1_vydx_q  <= vydx_w;
    s1_vxdx_q  <= vxdx_w;
    s1_vydy_q  <= vydy_w;

    sq_q[0]  <= sq0_w;
    sqd_q[0] <= ds_w;
    sqc_q[0] <= s1_c_q;
    for (int j = 0; j < NS; j++) begin
      sq_q[j+1]  <= pha_pkg::sqrt_step(sq_q[j], NS - 1 - j);
      sqd_q[j+1] <= sqd_q[j];
      sqc_q[j+1] <= sqc_q[j];
    end

    dv_q[1]  <= dv_next(dv0_w, ND - 1);
    dvc_q[1] <= sqc_q[NS];
    for (int j = 1; j < ND; j++) begin
      dv_q[j+1]  <= dv_next(dv_q[j], ND - 1 - j);
      dvc_q[j+1] <= dvc_q[j];
    end

    s3_c_q.vx  <= dvc_q[ND].vx;
    s3_c_q.vy  <= dvc_q[ND].vy;
    s3_c_q.rad <= dvc_q[ND].rad;
    s3_c_q.dt  <= dvc_q[ND].dt;
    s3_c_q.err <= dvc_q[ND].err | miss_w;
    s3_hq_q    <= dv_q[ND].qc[30:0];
    s3_h_q     <= h_w;
    s3_q_q     <= q_w;
    s3_sp_q    <= dv_q[ND].sp;

    s4_c_q   <= s3_c_q;
    s4_rr_q  <= s3_c_q.rad * s3_c_q.rad;
    s4_hh_q  <= s3_hq_q * s3_hq_q;
    s4_rhs_q <= s3_c_q.dt * s3_sp_q;
    s4_h_q   <= s3_h_q;
    s4_q_q   <= s3_q_q;

    mq_q[0].rem   <= {2'b00, msq_w};
    mq_q[0].root  <= '0;
    mqm_q[0].h    <= s4_h_q;
    mqm_q[0].q    <= s4_q_q;
    mqm_q[0].rhs  <= s4_rhs_q;
    mqc_q[0]      <= s4_c_q;
    for (int j = 0; j < NM; j++) begin
      mq_q[j+1]  <= pha_pkg::sqrt_step(mq_q[j], NM - 1 - j);
      mqm_q[j+1] <= mqm_q[j];
      mqc_q[j+1] <= mqc_q[j];
    end

    s6_c_q     <= mqc_q[NM];
    s6_later_q <= (lhs_w <= rhs_w);
    s6_m_q     <= m_w;
    s6_h_q     <= mqm_q[NM].h;

    s7_err_q <= s6_c_q.err;
    s7_hvy_q <= hvy_w;
    s7_mvx_q <= mvx_w;
    s7_hvx_q <= hvx_w;
    s7_mvy_q <= mvy_w;

    s8_q.hx  <= 65'(s7_mvx_q) - 65'(s7_hvy_q);
    s8_q.hy  <= 65'(s7_hvx_q) + 65'(s7_mvy_q);
    s8_q.err <= s7_err_q;
  end

  assign out_valid_o = s8_v_q;
  assign out_o       = s8_q;

endmodule

/* rtl/pha_angle.sv */
// Angle pipeline: magnitude normalization, CORDIC arctangent and quadrant mapping.
module pha_angle (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  pha_pkg::geo_res_t  in_i,
  output logic               done_o,
  output pha_pkg::out_item_t result_o
);

  localparam int NC = pha_pkg::CordicStages;

  typedef struct packed {
    logic sx;
    logic sy;
    logic err;
    logic zero;
  } am_t;

  // A1: magnitudes.
  logic signed [64:0] nhx_w, nhy_w;
  logic               a1_v_q;
  am_t                a1_m_q;
  logic [63:0]        a1_ux_q, a1_uy_q;

  assign nhx_w = -in_i.hx;
  assign nhy_w = -in_i.hy;

  // A2: larger magnitude.
  logic               a2_v_q;
  am_t                a2_m_q;
  logic [63:0]        a2_ux_q, a2_uy_q, a2_mx_q;

  // A3: leading one.
  logic               a3_v_q;
  am_t                a3_m_q;
  logic [63:0]        a3_ux_q, a3_uy_q;
  logic [5:0]         a3_pos_q;

  // A4: normalize so the larger magnitude lies in [2^29, 2^30).
  logic [5:0]         rsh_w, lsh_w;
  logic [63:0]        nx_w, ny_w;

  always_comb begin
    rsh_w = a3_pos_q - 6'd29;
    lsh_w = 6'd29 - a3_pos_q;
    nx_w  = (a3_pos_q > 6'd29) ? (a3_ux_q >> rsh_w) : (a3_ux_q << lsh_w);
    ny_w  = (a3_pos_q > 6'd29) ? (a3_uy_q >> rsh_w) : (a3_uy_q << lsh_w);
  end

  logic signed [33:0]         cx_q [0:NC];
  logic signed [33:0]         cy_q [0:NC];
  logic signed [pha_pkg::AngW-1:0] cz_q [0:NC];
  am_t                        cm_q [0:NC];
  logic                       cv_q [0:NC];

  // Final: clamp, quadrant, round.
  logic [pha_pkg::AngW-1:0]   zc_w, ang_w;
  logic [pha_pkg::AngW:0]     rnd_w;
  logic [8:0]                 deg_w;
  am_t                        fm_w;

  always_comb begin
    fm_w = cm_q[NC];
    if (cz_q[NC][pha_pkg::AngW-1]) begin
      zc_w = '0;
    end else if ($unsigned(cz_q[NC]) > pha_pkg::QuarterTurn) begin
      zc_w = pha_pkg::QuarterTurn;
    end else begin
      zc_w = $unsigned(cz_q[NC]);
    end
    if (!fm_w.sx && !fm_w.sy) begin
      ang_w = zc_w;
    end else if (fm_w.sx && !fm_w.sy) begin
      ang_w = pha_pkg::HalfTurn - zc_w;
    end else if (fm_w.sx) begin
      ang_w = pha_pkg::HalfTurn + zc_w;
    end else begin
      ang_w = pha_pkg::FullTurn - zc_w;
    end
    rnd_w = {1'b0, ang_w} + pha_pkg::RoundHalf;
    deg_w = rnd_w[24:16];
    if (deg_w == pha_pkg::Deg360 || fm_w.err || fm_w.zero) begin
      deg_w = '0;
    end
  end

  logic               out_v_q;
  pha_pkg::out_item_t out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a1_v_q  <= 1'b0;
      a2_v_q  <= 1'b0;
      a3_v_q  <= 1'b0;
      out_v_q <= 1'b0;
      for (int j = 0; j <= NC; j++) begin
        cv_q[j] <= 1'b0;
      end
    end else begin
      a1_v_q  <= in_valid_i;
      a2_v_q  <= a1_v_q;
      a3_v_q  <= a2_v_q;
      cv_q[0] <= a3_v_q;
      for (int j = 0; j < NC; j++) begin
        cv_q[j+1] <= cv_q[j];
      end
      out_v_q <= cv_q[NC];
    end
  end

  always_ff @(posedge clk_i) begin
    a1_ux_q     <= in_i.hx[64] ? nhx_w[63:0] : in_i.hx[63:0];
    a1_uy_q     <= in_i.hy[64] ? nhy_w[63:0] : in_i.hy[63:0];
    a1_m_q.sx   <= in_i.hx[64];
    a1_m_q.sy   <= in_i.hy[64];
    a1_m_q.err  <= in_i.err;
    a1_m_q.zero <= 1'b0;

    a2_ux_q <= a1_ux_q;
    a2_uy_q <= a1_uy_q;
    a2_mx_q <= (a1_ux_q > a1_uy_q) ? a1_ux_q : a1_uy_q;
    a2_m_q  <= a1_m_q;

    a3_ux_q     <= a2_ux_q;
    a3_uy_q     <= a2_uy_q;
    a3_pos_q    <= pha_pkg::lead_one(a2_mx_q);
    a3_m_q.sx   <= a2_m_q.sx;
    a3_m_q.sy   <= a2_m_q.sy;
    a3_m_q.err  <= a2_m_q.err;
    a3_m_q.zero <= (a2_mx_q == '0);

    cx_q[0] <= $signed({4'd0, nx_w[29:0]});
    cy_q[0] <= $signed({4'd0, ny_w[29:0]});
    cz_q[0] <= '0;
    cm_q[0] <= a3_m_q;
    for (int j = 0; j < NC; j++) begin
      if (!cy_q[j][33]) begin
        cx_q[j+1] <= cx_q[j] + (cy_q[j] >>> j);
        cy_q[j+1] <= cy_q[j] - (cx_q[j] >>> j);
        cz_q[j+1] <= cz_q[j] + $signed(pha_pkg::atan_deg(j));
      end else begin
        cx_q[j+1] <= cx_q[j] - (cy_q[j] >>> j);
        cy_q[j+1] <= cy_q[j] + (cx_q[j] >>> j);
        cz_q[j+1] <= cz_q[j] - $signed(pha_pkg::atan_deg(j));
      end
      cm_q[j+1] <= cm_q[j];
    end

    out_q.hit_angle_deg  <= deg_w;
    out_q.geometry_error <= fm_w.err;
  end

  assign done_o   = out_v_q;
  assign result_o = out_q;

endmodule

/* rtl/probe_hit_angle.sv */
// Top level of the probe hit angle block: front end, queue, geometry and angle pipelines.
//
// A particle that has just entered a circular probe is presented on item_i together with
// the probe centre and radius; the block traces it back along its velocity to the probe
// rim and returns the direction of that crossing, seen from the centre, in whole degrees.
// A transaction is taken at a rising edge where start is high and busy is low. Each
// transaction yields one result on result_o, marked by done_o for a single cycle; the
// receiver cannot hold a result off, and results leave in the order items arrived.
// The step-time registers are written through cfg_we_i, cfg_addr_i and cfg_wdata_i at
// any edge where cfg_we_i is high; addresses beyond the last register are ignored.
// The pipeline depth is set by 32 stages of speed square root, 34 of division, 31 of chord
// square root and 20 of CORDIC, each resolving one digit per stage, plus the stages of
// products, path offsets, squares, crossing choice, normalization and rounding.
// One transaction is taken every cycle; busy rises only if the queue between the front end
// and the pipelines fills.
// Reset clears the step-time registers to zero and empties every stage.
module probe_hit_angle (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start,
  output logic                          busy,
  input  logic                          cfg_we_i,
  input  logic [pha_pkg::CfgAddrW-1:0]  cfg_addr_i,
  input  logic [pha_pkg::StepW-1:0]     cfg_wdata_i,
  input  pha_pkg::in_item_t             item_i,
  output logic                          done_o,
  output pha_pkg::out_item_t            result_o
);

  logic              fe_valid;
  pha_pkg::fe_item_t fe_item;
  logic              fifo_full;
  logic              q_valid;
  pha_pkg::fe_item_t q_item;
  logic              geo_valid;
  pha_pkg::geo_res_t geo_res;

  // Front end: registers, capture and zero-speed classification.
  pha_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (start),
    .busy        (busy),
    .cfg_we_i    (cfg_we_i),
    .cfg_addr_i  (cfg_addr_i),
    .cfg_wdata_i (cfg_wdata_i),
    .item_i      (item_i),
    .fifo_full_i (fifo_full),
    .fe_valid_o  (fe_valid),
    .fe_item_o   (fe_item)
  );

  // The back end never stalls, so the queue drains one entry every cycle.
  pha_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (fe_valid),
    .data_i  (fe_item),
    .full_o  (fifo_full),
    .pop_i   (q_valid),
    .valid_o (q_valid),
    .data_o  (q_item)
  );

  // Back end, first half: crossing vector relative to the probe centre.
  pha_geom u_geom (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (q_valid),
    .in_item_i   (q_item),
    .out_valid_o (geo_valid),
    .out_o       (geo_res)
  );

  // Back end, second half: angle of that vector in whole degrees.
  pha_angle u_angle (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (geo_valid),
    .in_i       (geo_res),
    .done_o     (done_o),
    .result_o   (result_o)
  );

endmodule
